@@ hw/rtl/shdf_pkg.sv @@
package shdf_pkg;

  localparam int unsigned WinDepth = 7;

  localparam logic [7:0] Magic0   = 8'h0B;
  localparam logic [7:0] Magic1   = 8'hB0;
  localparam logic [7:0] Magic2   = 8'h21;
  // 8-bit sum of the three magic bytes
  localparam logic [7:0] MagicSum = 8'hDC;

  typedef enum logic {
    KIND_HEADER  = 1'b0,
    KIND_PAYLOAD = 1'b1
  } shdf_kind_e;

  typedef struct packed {
    shdf_kind_e  kind;
    logic [7:0]  data;
    logic [15:0] length;
    logic        last;
  } shdf_result_t;

endpackage

@@ hw/rtl/sync_header_packet_deframer_unit.sv @@
// Channel   Direction  Handshake                 Payload
// in        input      in_valid_i / in_stall_o   rx_byte_i[7:0]
// out       output     out_valid_o / out_stall_i kind_o, data_o[7:0], length_o[15:0], last_o
//
// One byte is taken every cycle while the input does not stall; each byte is held
// in the input register and its result is then loaded into the result register.
// The header compare, 8-bit check sum and payload counter sit between the
// two registers.
// Reset clears the seven-byte window, the length, the count and both valids.
// An output stall holds the result register; the input stalls only when a
// byte that yields a result waits behind a stalled, full result register.
module sync_header_packet_deframer_unit
  import shdf_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        kind_o,
  output logic [7:0]  data_o,
  output logic [15:0] length_o,
  output logic        last_o
);

  logic         s1_valid;
  logic [7:0]   s1_byte;
  logic         has_result;
  logic         consume;
  logic         load;
  shdf_result_t core_res;
  shdf_result_t out_res;

  // A byte leaves the input register when it yields nothing, or when the
  // result register is free or being drained this cycle.
  assign consume = s1_valid & (~has_result | ~out_valid_o | ~out_stall_i);
  assign load    = consume & has_result;

  shdf_in_stage u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .rx_byte_i  (rx_byte_i),
    .consume_i  (consume),
    .s1_valid_o (s1_valid),
    .s1_byte_o  (s1_byte)
  );

  // Window, header match and payload counting; state moves only on consume.
  shdf_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s1_byte_i    (s1_byte),
    .consume_i    (consume),
    .has_result_o (has_result),
    .result_o     (core_res)
  );

  shdf_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (load),
    .result_i    (core_res),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .result_o    (out_res)
  );

  assign kind_o   = out_res.kind;
  assign data_o   = out_res.data;
  assign length_o = out_res.length;
  assign last_o   = out_res.last;

`ifndef SYNTHESIS
  // A result that is loaded must show up as valid on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni) load |=> out_valid_o)
    else $error("loaded result not presented");

  // Stall the input only while a byte is actually held.
  assert property (@(posedge clk_i) disable iff (!rst_ni) in_stall_o |-> s1_valid)
    else $error("input stalled with empty input register");

  // A zero-length header ends the packet at once.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      (out_valid_o && kind_o == KIND_HEADER && length_o == 16'd0) |-> last_o)
    else $error("zero-length header without last");

  // Never overwrite a result that is stalled on the output.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      (out_valid_o && out_stall_i) |-> !load)
    else $error("stalled result overwritten");
`endif

endmodule

@@ hw/rtl/shdf_in_stage.sv @@
module shdf_in_stage
  import shdf_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] rx_byte_i,
  input  logic       consume_i,
  output logic       s1_valid_o,
  output logic [7:0] s1_byte_o
);

  logic       valid_q, valid_d;
  logic [7:0] byte_q;
  logic       accept;

  // hold the byte while the core cannot take it
  assign in_stall_o = valid_q & ~consume_i;
  assign accept     = in_valid_i & ~in_stall_o;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (consume_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      byte_q <= rx_byte_i;
    end
  end

  assign s1_valid_o = valid_q;
  assign s1_byte_o  = byte_q;

endmodule

@@ hw/rtl/shdf_core.sv @@
module shdf_core
  import shdf_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic [7:0]   s1_byte_i,
  input  logic         consume_i,
  output logic         has_result_o,
  output shdf_result_t result_o
);

  logic [7:0]  win_q [WinDepth];
  logic        in_payload_q, in_payload_d;
  logic [15:0] len_q, len_d;
  logic [15:0] cnt_q, cnt_d;

  logic [7:0]  sum;
  logic        match;
  logic [15:0] hdr_len;
  logic [15:0] cnt_inc;
  logic        done;

  assign sum     = MagicSum + win_q[4] + win_q[5] + win_q[6] + s1_byte_i;
  assign match   = (win_q[0] == Magic0) && (win_q[1] == Magic1) &&
                   (win_q[2] == Magic2) && (win_q[3] == ~sum);
  assign hdr_len = {win_q[5], win_q[4]};
  assign cnt_inc = cnt_q + 16'd1;
  assign done    = cnt_inc >= len_q;

  always_comb begin
    in_payload_d = in_payload_q;
    len_d        = len_q;
    cnt_d        = cnt_q;
    has_result_o = 1'b0;
    result_o     = '0;
    if (in_payload_q) begin
      has_result_o    = 1'b1;
      result_o.kind   = KIND_PAYLOAD;
      result_o.data   = s1_byte_i;
      result_o.length = len_q;
      result_o.last   = done;
      cnt_d           = done ? 16'd0 : cnt_inc;
      in_payload_d    = ~done;
    end else if (match) begin
      has_result_o    = 1'b1;
      result_o.kind   = KIND_HEADER;
      result_o.length = hdr_len;
      result_o.last   = (hdr_len == 16'd0);
      len_d           = hdr_len;
      cnt_d           = 16'd0;
      in_payload_d    = (hdr_len != 16'd0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_payload_q <= 1'b0;
      len_q        <= '0;
      cnt_q        <= '0;
      for (int i = 0; i < WinDepth; i++) begin
        win_q[i] <= '0;
      end
    end else if (consume_i) begin
      in_payload_q <= in_payload_d;
      len_q        <= len_d;
      cnt_q        <= cnt_d;
      // advance the window only on a miss while hunting
      if (!in_payload_q && !match) begin
        for (int i = 0; i < WinDepth - 1; i++) begin
          win_q[i] <= win_q[i+1];
        end
        win_q[WinDepth-1] <= s1_byte_i;
      end
    end
  end

endmodule

@@ hw/rtl/shdf_out_stage.sv @@
module shdf_out_stage
  import shdf_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         load_i,
  input  shdf_result_t result_i,
  output logic         out_valid_o,
  input  logic         out_stall_i,
  output shdf_result_t result_o
);

  logic         valid_q, valid_d;
  shdf_result_t res_q;

  assign valid_d = (valid_q & out_stall_i) | load_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign result_o    = res_q;

endmodule

@@ dv/shdf_deframe_checker.sv @@
`timescale 1ns / 100ps

module shdf_deframe_checker
  import shdf_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [7:0]  rx_byte_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic        kind_i,
  input  logic [7:0]  data_i,
  input  logic [15:0] length_i,
  input  logic        last_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          results_seen_o,
  output int          headers_seen_o
);

  logic [7:0]   hunt_win [WinDepth];
  logic         streaming;
  logic [15:0]  pkt_len;
  logic [15:0]  pkt_cnt;

  shdf_result_t frame_results_q [$];
  shdf_result_t predicted;
  shdf_result_t observed;
  shdf_result_t oldest;
  int           fails;
  int           results_seen;
  int           headers_seen;

  // Advance the deframer state by one byte; return 1 when the byte yields a result.
  function automatic bit deframe_byte(input logic [7:0] b, output shdf_result_t res);
    logic [7:0]  sum;
    logic [15:0] hdr_len;
    res = '0;
    if (streaming) begin
      pkt_cnt    = pkt_cnt + 16'd1;
      res.kind   = KIND_PAYLOAD;
      res.data   = b;
      res.length = pkt_len;
      res.last   = (pkt_cnt >= pkt_len);
      if (res.last) begin
        streaming = 1'b0;
        pkt_cnt   = '0;
      end
      return 1'b1;
    end
    sum = MagicSum + hunt_win[4] + hunt_win[5] + hunt_win[6] + b;
    if (hunt_win[0] == Magic0 && hunt_win[1] == Magic1 && hunt_win[2] == Magic2 &&
        hunt_win[3] == ~sum) begin
      hdr_len    = {hunt_win[5], hunt_win[4]};
      pkt_len    = hdr_len;
      pkt_cnt    = '0;
      streaming  = (hdr_len != 16'd0);
      res.kind   = KIND_HEADER;
      res.length = hdr_len;
      res.last   = (hdr_len == 16'd0);
      return 1'b1;
    end
    // no match: slide the window, keep it untouched on a match
    for (int i = 0; i < WinDepth - 1; i++) hunt_win[i] = hunt_win[i + 1];
    hunt_win[WinDepth - 1] = b;
    return 1'b0;
  endfunction

  task automatic compare_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
    if (want !== got) begin
      fails++;
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (hunt_win[i]) hunt_win[i] = '0;
      streaming = 1'b0;
      pkt_len   = '0;
      pkt_cnt   = '0;
      frame_results_q.delete();
      pending_o <= 0;
    end else begin
      // compare the outgoing transfer before predicting the incoming one
      if (out_valid_i && !out_stall_i) begin
        observed = shdf_result_t'({kind_i, data_i, length_i, last_i});
        results_seen++;
        if (frame_results_q.size() == 0) begin
          fails++;
          $display("%0t: result with nothing expected, actual kind %0d data 0x%0h",
                   $time, kind_i, data_i);
          $display("%0t:   actual length 0x%0h last %0d", $time, length_i, last_i);
        end else begin
          oldest = frame_results_q.pop_front();
          compare_field("kind", oldest.kind, observed.kind);
          compare_field("data", oldest.data, observed.data);
          compare_field("length", oldest.length, observed.length);
          compare_field("last", oldest.last, observed.last);
          if (oldest.kind == KIND_HEADER) headers_seen++;
        end
      end
      if (in_valid_i && !in_stall_i) begin
        if (deframe_byte(rx_byte_i, predicted)) frame_results_q.push_back(predicted);
      end
      pending_o <= frame_results_q.size();
    end
    fail_count_o   <= fails;
    results_seen_o <= results_seen;
    headers_seen_o <= headers_seen;
  end

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
  import shdf_pkg::*;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic [7:0]  rx_byte   = 8'h00;
  logic        out_stall = 1'b0;
  logic        in_stall;
  logic        out_valid;
  logic        kind;
  logic [7:0]  data;
  logic [15:0] length;
  logic        last;

  int fail_count;
  int pending;
  int results_seen;
  int headers_seen;
  int bytes_sent   = 0;
  int framed_bytes = 0;

  // Per-phase switches: when clear, that side runs with no gaps at all.
  bit send_idle_on = 1'b1;
  bit recv_idle_on = 1'b1;

  always #5 clk = ~clk;

  sync_header_packet_deframer_unit i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .rx_byte_i   (rx_byte),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .kind_o      (kind),
    .data_o      (data),
    .length_o    (length),
    .last_o      (last)
  );

  shdf_deframe_checker i_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_i     (in_stall),
    .rx_byte_i      (rx_byte),
    .out_valid_i    (out_valid),
    .out_stall_i    (out_stall),
    .kind_i         (kind),
    .data_i         (data),
    .length_i       (length),
    .last_i         (last),
    .fail_count_o   (fail_count),
    .pending_o      (pending),
    .results_seen_o (results_seen),
    .headers_seen_o (headers_seen)
  );

  // Offer one byte after a random gap and hold it until the transfer happens.
  // Valid stays high on return so a back-to-back byte needs no second assignment.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = send_idle_on ? $urandom_range(0, 3) : 0;
    repeat (gap) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk); while (in_stall);
    bytes_sent++;
  endtask

  // Build an 8-byte header with a correct check byte; flip one bit of it
  // (flip_bit 0..63) to make a corrupted header, or pass -1 to keep it intact.
  task automatic send_header(input logic [15:0] len, input logic [7:0] tail_a,
                             input logic [7:0] tail_b, input int flip_bit);
    logic [7:0] hdr [8];
    logic [7:0] sum;
    sum = MagicSum + len[7:0] + len[15:8] + tail_a + tail_b;
    hdr = '{Magic0, Magic1, Magic2, ~sum, len[7:0], len[15:8], tail_a, tail_b};
    if (flip_bit >= 0) hdr[flip_bit / 8] ^= 8'(1 << (flip_bit % 8));
    foreach (hdr[i]) send_byte(hdr[i]);
  endtask

  // Send a full packet. With again set, repeat the header's final byte after the
  // payload: the window still holds that header, so it matches once more and a
  // second payload of the same length follows.
  task automatic send_packet(input logic [15:0] len, input logic [7:0] tail, input bit again);
    send_header(len, 8'($urandom), tail, -1);
    repeat (len) send_byte(8'($urandom));
    framed_bytes += 8 + len;
    if (again) begin
      send_byte(tail);
      repeat (len) send_byte(8'($urandom));
      framed_bytes += 1 + len;
    end
  endtask

  // Receiver: before each result, stall for a random number of cycles, then
  // take it as soon as it shows up.
  initial begin : recv_side
    int hold;
    forever begin
      hold = recv_idle_on ? $urandom_range(0, 3) : 0;
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Hard stop in case the block hangs; sized for the whole byte count at the
  // slowest pace of both sides, many times over.
  initial begin : watchdog
    #2_000_000;
    $display("Timeout with %0d results still outstanding", pending);
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin : stimulus
    int          sel;
    int          drain;
    logic [15:0] len;
    bit          paused;
    paused = 1'b0;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // --- directed part ---
    // Zero length: the header result ends the packet by itself.
    send_header(16'h0000, 8'h00, 8'hFF, -1);
    // Window was left alone by the match: repeating the final byte matches again.
    send_byte(8'hFF);
    // Any other byte misses and slides the window.
    send_byte(8'h00);
    // Two payload bytes at the data extremes, last flag on the second.
    send_header(16'h0002, 8'hFF, 8'h00, -1);
    send_byte(8'h00);
    send_byte(8'hFF);
    // Bad check byte: no result, window just slides through it.
    send_header(16'h0003, 8'h12, 8'h34, 24);
    // Partial sync word right before a real header.
    send_byte(Magic0);
    send_byte(Magic1);
    send_packet(16'h0001, 8'h80, 1'b0);
    // Header straight after the last payload byte.
    send_packet(16'h0000, 8'h3C, 1'b0);
    // A valid header carried as payload is passed through, not matched.
    send_header(16'h0008, 8'h01, 8'h02, -1);
    send_header(16'h0000, 8'hAA, 8'h55, -1);
    // Re-match with a nonzero length.
    send_packet(16'h0002, 8'h77, 1'b1);
    // Length with a nonzero upper byte; drop the sender gaps for this one, and
    // follow with a byte that cannot re-match this header.
    send_idle_on = 1'b0;
    send_packet(16'h0100, 8'h5A, 1'b0);
    send_idle_on = 1'b1;
    send_byte(8'hA5);

    // --- random part: mostly well-formed packets, some corruption and noise ---
    while (framed_bytes < 500) begin
      send_idle_on = ($urandom_range(0, 4) != 0);
      recv_idle_on = ($urandom_range(0, 4) != 0);
      sel = $urandom_range(0, 9);
      if (sel < 7) begin
        repeat ($urandom_range(0, 2)) send_byte(8'($urandom));
        len = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(5, 40))
                                          : 16'($urandom_range(0, 4));
        send_packet(len, 8'($urandom), $urandom_range(0, 3) == 0);
      end else if (sel < 9) begin
        send_header(16'($urandom), 8'($urandom), 8'($urandom), $urandom_range(0, 63));
      end else begin
        repeat ($urandom_range(1, 8)) send_byte(8'($urandom));
      end

      // Once, halfway through: hold off until the block has drained.
      if (!paused && framed_bytes >= 250) begin
        paused = 1'b1;
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
      end
    end

    // Drop valid and let the last results drain, with a bound.
    in_valid <= 1'b0;
    drain = 0;
    do begin
      @(posedge clk);
      drain++;
    end while (pending != 0 && drain < 5000);
    repeat (10) @(posedge clk);

    if (pending != 0) $display("%0d expected results never arrived", pending);
    $display("Summary: %0d bytes transferred in, %0d results compared, %0d of them headers",
             bytes_sent, results_seen, headers_seen);
    $display("Summary: zero, short and two-byte lengths, header re-match, corrupted headers, noise");
    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/shdf_pkg.sv
hw/rtl/shdf_in_stage.sv
hw/rtl/shdf_core.sv
hw/rtl/shdf_out_stage.sv
hw/rtl/sync_header_packet_deframer_unit.sv
dv/shdf_deframe_checker.sv
dv/testbench.sv
